// ===== hdl/bbpq_pkg.sv =====
// Shared types, codes and constants of the blocking buffer pool queue.
`default_nettype none

package bbpq_pkg;

    localparam int KIND_W = 3;
    localparam int ID_W   = 4;
    localparam int BUF_W  = 4;
    localparam int STAT_W = 3;
    localparam int CFG_W  = 5;
    localparam int NUM_IDS = 2 ** ID_W;

    localparam int DEF_MAX_BLOCKS     = 16;
    localparam int DEF_MAX_REQUESTERS = 16;
    localparam int POOL_CAP           = 16;
    localparam logic [CFG_W-1:0] BLOCKS_RESET = CFG_W'(16);

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC   = 3'd0,
        K_PUSH    = 3'd1,
        K_PULL    = 3'd2,
        K_RELEASE = 3'd3,
        K_CANCEL  = 3'd4,
        K_RESET   = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_WAITING   = 3'd1,
        ST_HANDED    = 3'd2,
        ST_STORED    = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_WOKEN     = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_INIT_START,
        S_INIT_FILL,
        S_IDLE,
        S_DISPATCH,
        S_GRANT,
        S_HAND,
        S_STORED,
        S_CAN_READ,
        S_CAN_CHECK,
        S_RST_READ,
        S_RST_EMIT,
        S_RST_START,
        S_RST_FILL,
        S_SUMMARY
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SRC_POP,
        OP_DST_APPEND,
        OP_WL_APPEND,
        OP_WL_POP,
        OP_HAND_CLR,
        OP_WALK_READ,
        OP_WALK_CHECK,
        OP_CAN_DROP,
        OP_LIST_NEXT,
        OP_FILL_START,
        OP_FILL_STEP
    } t_op;

    typedef enum logic [3:0] {
        RES_GRANT,
        RES_WAIT,
        RES_REFUSE,
        RES_HAND,
        RES_STORED,
        RES_DROP,
        RES_CANCEL,
        RES_WOKEN,
        RES_SUMMARY
    } t_res;

    typedef struct packed {
        t_op  op;
        logic emit;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              src_nonempty;
        logic              dst_full;
        logic              wl_nonempty;
        logic              waiters_full;
        logic              member;
        logic              walk_end;
        logic              last_list;
        logic              fill_done;
        logic              out_free;
    } t_stat;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   target;
        logic [BUF_W-1:0]  buffer_out;
        logic              buffer_valid;
        logic              queue_empty;
        logic              pool_full;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/bbpq_if.sv =====
// Request and response channel interfaces of the blocking buffer pool queue.
`default_nettype none

interface bbpq_req_if;
    logic                         valid;
    logic                         ready;
    logic [bbpq_pkg::KIND_W-1:0]  kind;
    logic [bbpq_pkg::ID_W-1:0]    requester;
    logic [bbpq_pkg::BUF_W-1:0]   buffer_index;

    modport source (output valid, kind, requester, buffer_index, input ready);
    modport sink   (input valid, kind, requester, buffer_index, output ready);
endinterface

interface bbpq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bbpq_pkg::STAT_W-1:0]  status;
    logic [bbpq_pkg::ID_W-1:0]    target;
    logic [bbpq_pkg::BUF_W-1:0]   buffer_out;
    logic                         buffer_valid;
    logic                         queue_empty;
    logic                         pool_full;
    logic                         last;

    modport source (output valid, status, target, buffer_out, buffer_valid, queue_empty,
                    pool_full, last, input ready);
    modport sink   (input valid, status, target, buffer_out, buffer_valid, queue_empty,
                    pool_full, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/bbpq_ring.sv =====
// Circular list in a memory with head pointer and fill count.
`default_nettype none

module bbpq_ring #(
    parameter int DEPTH = bbpq_pkg::DEF_MAX_BLOCKS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_rd,
    input  wire  [$clog2(DEPTH)-1:0]     i_rd_off,
    input  wire                          i_wr,
    input  wire  [$clog2(DEPTH)-1:0]     i_wr_off,
    input  wire  [bbpq_pkg::ID_W-1:0]    i_wr_data,
    input  wire                          i_pop,
    input  wire                          i_push,
    input  wire                          i_drop,
    input  wire                          i_clear,
    output logic [bbpq_pkg::ID_W-1:0]    o_rdata,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [bbpq_pkg::ID_W-1:0] mem [DEPTH];
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [bbpq_pkg::ID_W-1:0] r_rdata;
    logic [IW:0]   rd_sum;
    logic [IW:0]   wr_sum;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] n_head;
    logic [CW-1:0] n_count;

    // wrap head + offset into the ring
    always_comb begin
        rd_sum = {1'b0, r_head} + {1'b0, i_rd_off};
        wr_sum = {1'b0, r_head} + {1'b0, i_wr_off};
        if (rd_sum >= (IW+1)'(DEPTH)) begin
            rd_addr = IW'(rd_sum - (IW+1)'(DEPTH));
        end else begin
            rd_addr = rd_sum[IW-1:0];
        end
        if (wr_sum >= (IW+1)'(DEPTH)) begin
            wr_addr = IW'(wr_sum - (IW+1)'(DEPTH));
        end else begin
            wr_addr = wr_sum[IW-1:0];
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_clear) begin
            n_head  = '0;
            n_count = '0;
        end else begin
            if (i_pop) begin
                n_head = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
            end
            n_count = r_count + CW'(i_push) - CW'(i_pop) - CW'(i_drop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[wr_addr] <= i_wr_data;
        end
        if (i_rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hdl/bbpq_datapath.sv =====
// Datapath: buffer and waiter rings, membership flags, walk counters, result register.
`default_nettype none

module bbpq_datapath #(
    parameter int MAX_BLOCKS     = bbpq_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_REQUESTERS = bbpq_pkg::DEF_MAX_REQUESTERS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  bbpq_pkg::t_cmd                 i_cmd,
    output bbpq_pkg::t_stat                o_stat,
    input  wire  [bbpq_pkg::KIND_W-1:0]    i_kind,
    input  wire  [bbpq_pkg::ID_W-1:0]      i_requester,
    input  wire  [bbpq_pkg::BUF_W-1:0]     i_buffer_index,
    input  wire  [bbpq_pkg::CFG_W-1:0]     i_blocks,
    output logic                           o_res_valid,
    input  wire                            i_res_ready,
    output bbpq_pkg::t_result              o_res
);
    localparam int BIW = $clog2(MAX_BLOCKS);
    localparam int BCW = $clog2(MAX_BLOCKS + 1);
    localparam int WIW = $clog2(MAX_REQUESTERS);
    localparam int WCW = $clog2(MAX_REQUESTERS + 1);
    localparam int FILL_MAX = (MAX_BLOCKS < bbpq_pkg::POOL_CAP) ? MAX_BLOCKS
                                                                : bbpq_pkg::POOL_CAP;
    localparam int IDW = bbpq_pkg::ID_W;

    // ring 0: free / push-waiters, ring 1: filled / pull-waiters
    logic [1:0]     b_rd, b_wr, b_pop, b_push, b_clear;
    logic [BIW-1:0] b_rd_off  [2];
    logic [BIW-1:0] b_wr_off  [2];
    logic [IDW-1:0] b_wr_data [2];
    logic [IDW-1:0] b_rdata   [2];
    logic [BCW-1:0] b_count   [2];

    logic [1:0]     w_rd, w_wr, w_pop, w_push, w_drop, w_clear;
    logic [WIW-1:0] w_rd_off  [2];
    logic [WIW-1:0] w_wr_off  [2];
    logic [IDW-1:0] w_wr_data [2];
    logic [IDW-1:0] w_rdata   [2];
    logic [WCW-1:0] w_count   [2];

    logic [bbpq_pkg::KIND_W-1:0] r_kind;
    logic [IDW-1:0]              r_who;
    logic [bbpq_pkg::BUF_W-1:0]  r_buf;

    logic [bbpq_pkg::NUM_IDS-1:0] r_mem_push, r_mem_pull;
    logic [WCW-1:0] r_walk;
    logic           r_found;
    logic           r_lsel;
    logic [BCW-1:0] r_fill;
    logic [BCW-1:0] r_fill_n;

    logic                 r_out_valid;
    bbpq_pkg::t_result    r_out;
    bbpq_pkg::t_result    n_out;

    logic                 bsel, wsel, out_free;
    logic [WCW-1:0]       walk_m2;
    logic [WCW:0]         waiters_total;
    logic [bbpq_pkg::CFG_W-1:0] blocks_lim;

    for (genvar g = 0; g < 2; g++) begin : g_rings
        bbpq_ring #(.DEPTH(MAX_BLOCKS)) u_buf_ring (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_rd      (b_rd[g]),
            .i_rd_off  (b_rd_off[g]),
            .i_wr      (b_wr[g]),
            .i_wr_off  (b_wr_off[g]),
            .i_wr_data (b_wr_data[g]),
            .i_pop     (b_pop[g]),
            .i_push    (b_push[g]),
            .i_drop    (1'b0),
            .i_clear   (b_clear[g]),
            .o_rdata   (b_rdata[g]),
            .o_count   (b_count[g])
        );
        bbpq_ring #(.DEPTH(MAX_REQUESTERS)) u_wait_ring (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_rd      (w_rd[g]),
            .i_rd_off  (w_rd_off[g]),
            .i_wr      (w_wr[g]),
            .i_wr_off  (w_wr_off[g]),
            .i_wr_data (w_wr_data[g]),
            .i_pop     (w_pop[g]),
            .i_push    (w_push[g]),
            .i_drop    (w_drop[g]),
            .i_clear   (w_clear[g]),
            .o_rdata   (w_rdata[g]),
            .o_count   (w_count[g])
        );
    end

    // allocate and release work on free + push-waiters, push and pull on filled + pull-waiters
    always_comb begin
        bsel = (r_kind == bbpq_pkg::K_PUSH) || (r_kind == bbpq_pkg::K_PULL);
        if (r_kind == bbpq_pkg::K_CANCEL) begin
            wsel = !r_mem_push[r_who];
        end else if (r_kind == bbpq_pkg::K_RESET) begin
            wsel = r_lsel;
        end else begin
            wsel = bsel;
        end
        walk_m2       = r_walk - WCW'(2);
        waiters_total = {1'b0, w_count[0]} + {1'b0, w_count[1]};
        out_free      = !r_out_valid || i_res_ready;
    end

    always_comb begin
        if (i_blocks == '0) begin
            blocks_lim = bbpq_pkg::CFG_W'(1);
        end else if (int'(i_blocks) > FILL_MAX) begin
            blocks_lim = bbpq_pkg::CFG_W'(FILL_MAX);
        end else begin
            blocks_lim = i_blocks;
        end
    end

    always_comb begin
        o_stat.kind         = r_kind;
        o_stat.src_nonempty = b_count[bsel] != '0;
        o_stat.dst_full     = b_count[bsel] == BCW'(MAX_BLOCKS);
        o_stat.wl_nonempty  = w_count[wsel] != '0;
        o_stat.waiters_full = waiters_total >= (WCW+1)'(MAX_REQUESTERS);
        o_stat.member       = r_mem_push[r_who] || r_mem_pull[r_who];
        o_stat.walk_end     = r_walk == w_count[wsel];
        o_stat.last_list    = r_lsel;
        o_stat.fill_done    = r_fill == r_fill_n;
        o_stat.out_free     = out_free;
    end

    // ring commands
    always_comb begin
        b_rd = '0; b_wr = '0; b_pop = '0; b_push = '0; b_clear = '0;
        w_rd = '0; w_wr = '0; w_pop = '0; w_push = '0; w_drop = '0; w_clear = '0;
        for (int k = 0; k < 2; k++) begin
            b_rd_off[k]  = '0;
            b_wr_off[k]  = b_count[k][BIW-1:0];
            b_wr_data[k] = r_buf;
            w_rd_off[k]  = '0;
            w_wr_off[k]  = w_count[k][WIW-1:0];
            w_wr_data[k] = r_who;
        end
        unique case (i_cmd.op)
            bbpq_pkg::OP_SRC_POP: begin
                b_rd[bsel]  = 1'b1;
                b_pop[bsel] = 1'b1;
            end
            bbpq_pkg::OP_DST_APPEND: begin
                b_wr[bsel]   = 1'b1;
                b_push[bsel] = 1'b1;
            end
            bbpq_pkg::OP_WL_APPEND: begin
                w_wr[wsel]   = 1'b1;
                w_push[wsel] = 1'b1;
            end
            bbpq_pkg::OP_WL_POP: begin
                w_rd[wsel]  = 1'b1;
                w_pop[wsel] = 1'b1;
            end
            bbpq_pkg::OP_WALK_READ: begin
                w_rd[wsel]     = 1'b1;
                w_rd_off[wsel] = r_walk[WIW-1:0];
            end
            bbpq_pkg::OP_WALK_CHECK: begin
                // close the gap: move the entry just read one place toward the head
                if (r_found) begin
                    w_wr[wsel]      = 1'b1;
                    w_wr_off[wsel]  = walk_m2[WIW-1:0];
                    w_wr_data[wsel] = w_rdata[wsel];
                end
            end
            bbpq_pkg::OP_CAN_DROP: begin
                w_drop[wsel] = 1'b1;
            end
            bbpq_pkg::OP_FILL_START: begin
                b_clear = '1;
                w_clear = '1;
            end
            bbpq_pkg::OP_FILL_STEP: begin
                b_wr[0]      = 1'b1;
                b_push[0]    = 1'b1;
                b_wr_data[0] = IDW'(r_fill);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bbpq_pkg::OP_LOAD) begin
            r_kind <= i_kind;
            r_who  <= i_requester;
            r_buf  <= i_buffer_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk     <= '0;
            r_found    <= 1'b0;
            r_lsel     <= 1'b0;
            r_fill     <= '0;
            r_fill_n   <= '0;
            r_mem_push <= '0;
            r_mem_pull <= '0;
        end else begin
            unique case (i_cmd.op)
                bbpq_pkg::OP_LOAD: begin
                    r_walk  <= '0;
                    r_found <= 1'b0;
                    r_lsel  <= 1'b0;
                end
                bbpq_pkg::OP_WL_APPEND: begin
                    if (wsel) begin
                        r_mem_pull[r_who] <= 1'b1;
                    end else begin
                        r_mem_push[r_who] <= 1'b1;
                    end
                end
                bbpq_pkg::OP_HAND_CLR: begin
                    r_mem_push[w_rdata[wsel]] <= 1'b0;
                    r_mem_pull[w_rdata[wsel]] <= 1'b0;
                end
                bbpq_pkg::OP_WALK_READ: begin
                    r_walk <= r_walk + WCW'(1);
                end
                bbpq_pkg::OP_WALK_CHECK: begin
                    if (!r_found && (w_rdata[wsel] == r_who)) begin
                        r_found <= 1'b1;
                    end
                end
                bbpq_pkg::OP_CAN_DROP: begin
                    r_mem_push[r_who] <= 1'b0;
                    r_mem_pull[r_who] <= 1'b0;
                end
                bbpq_pkg::OP_LIST_NEXT: begin
                    r_lsel <= 1'b1;
                    r_walk <= '0;
                end
                bbpq_pkg::OP_FILL_START: begin
                    r_mem_push <= '0;
                    r_mem_pull <= '0;
                    r_fill     <= '0;
                    r_fill_n   <= BCW'(blocks_lim);
                end
                bbpq_pkg::OP_FILL_STEP: begin
                    r_fill <= r_fill + BCW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // result formatting
    always_comb begin
        n_out.status       = bbpq_pkg::ST_GRANTED;
        n_out.target       = r_who;
        n_out.buffer_out   = '0;
        n_out.buffer_valid = 1'b0;
        n_out.queue_empty  = b_count[1] == '0;
        n_out.pool_full    = b_count[0] == '0;
        n_out.last         = 1'b1;
        unique case (i_cmd.res)
            bbpq_pkg::RES_GRANT: begin
                n_out.buffer_out   = b_rdata[bsel];
                n_out.buffer_valid = 1'b1;
            end
            bbpq_pkg::RES_WAIT: begin
                n_out.status = bbpq_pkg::ST_WAITING;
            end
            bbpq_pkg::RES_REFUSE: begin
                n_out.status = bbpq_pkg::ST_NOT_FOUND;
            end
            bbpq_pkg::RES_HAND: begin
                n_out.status       = bbpq_pkg::ST_HANDED;
                n_out.target       = w_rdata[wsel];
                n_out.buffer_out   = r_buf;
                n_out.buffer_valid = 1'b1;
            end
            bbpq_pkg::RES_STORED: begin
                n_out.status = bbpq_pkg::ST_STORED;
                n_out.target = '0;
            end
            bbpq_pkg::RES_DROP: begin
                n_out.status       = bbpq_pkg::ST_NOT_FOUND;
                n_out.target       = '0;
                n_out.buffer_out   = r_buf;
                n_out.buffer_valid = 1'b1;
            end
            bbpq_pkg::RES_CANCEL: begin
                n_out.status = bbpq_pkg::ST_CANCELLED;
            end
            bbpq_pkg::RES_WOKEN: begin
                // flags report the pool as it stands once the refill is done
                n_out.status      = bbpq_pkg::ST_WOKEN;
                n_out.target      = w_rdata[wsel];
                n_out.queue_empty = 1'b1;
                n_out.pool_full   = 1'b0;
                n_out.last        = 1'b0;
            end
            bbpq_pkg::RES_SUMMARY: begin
                n_out.target = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_waiter_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        waiters_total <= (WCW+1)'(MAX_REQUESTERS))
        else $error("waiter lists exceed capacity");

    a_single_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mem_push & r_mem_pull) == '0)
        else $error("requester marked in both waiter lists");

    a_drop_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == bbpq_pkg::OP_CAN_DROP) |-> r_found)
        else $error("cancel walk ended without finding the requester");

    a_clean_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.buffer_valid) |-> (r_out.buffer_out == '0))
        else $error("buffer field set on a beat without a buffer");

endmodule

`default_nettype wire

// ===== hdl/bbpq_ctrl.sv =====
// Controller state machine sequencing each request through the datapath.
`default_nettype none

module bbpq_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  bbpq_pkg::t_stat  i_stat,
    output bbpq_pkg::t_cmd   o_cmd
);
    bbpq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbpq_pkg::S_INIT_START;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbpq_pkg::S_INIT_START: n_state = bbpq_pkg::S_INIT_FILL;
            bbpq_pkg::S_INIT_FILL: begin
                if (i_stat.fill_done) n_state = bbpq_pkg::S_IDLE;
            end
            bbpq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bbpq_pkg::S_DISPATCH;
            end
            bbpq_pkg::S_DISPATCH: begin
                unique case (i_stat.kind)
                    bbpq_pkg::K_ALLOC, bbpq_pkg::K_PULL: begin
                        if (i_stat.src_nonempty) begin
                            n_state = bbpq_pkg::S_GRANT;
                        end else if (i_stat.out_free) begin
                            n_state = bbpq_pkg::S_IDLE;
                        end
                    end
                    bbpq_pkg::K_PUSH, bbpq_pkg::K_RELEASE: begin
                        if (i_stat.wl_nonempty) begin
                            n_state = bbpq_pkg::S_HAND;
                        end else if (!i_stat.dst_full) begin
                            n_state = bbpq_pkg::S_STORED;
                        end else if (i_stat.out_free) begin
                            n_state = bbpq_pkg::S_IDLE;
                        end
                    end
                    bbpq_pkg::K_CANCEL: begin
                        if (i_stat.member) begin
                            n_state = bbpq_pkg::S_CAN_READ;
                        end else if (i_stat.out_free) begin
                            n_state = bbpq_pkg::S_IDLE;
                        end
                    end
                    bbpq_pkg::K_RESET: n_state = bbpq_pkg::S_RST_READ;
                    default:           n_state = bbpq_pkg::S_IDLE;
                endcase
            end
            bbpq_pkg::S_GRANT, bbpq_pkg::S_HAND, bbpq_pkg::S_STORED,
            bbpq_pkg::S_SUMMARY: begin
                if (i_stat.out_free) n_state = bbpq_pkg::S_IDLE;
            end
            bbpq_pkg::S_CAN_READ: begin
                if (!i_stat.walk_end) begin
                    n_state = bbpq_pkg::S_CAN_CHECK;
                end else if (i_stat.out_free) begin
                    n_state = bbpq_pkg::S_IDLE;
                end
            end
            bbpq_pkg::S_CAN_CHECK: n_state = bbpq_pkg::S_CAN_READ;
            bbpq_pkg::S_RST_READ: begin
                if (!i_stat.walk_end) begin
                    n_state = bbpq_pkg::S_RST_EMIT;
                end else if (i_stat.last_list) begin
                    n_state = bbpq_pkg::S_RST_START;
                end
            end
            bbpq_pkg::S_RST_EMIT: begin
                if (i_stat.out_free) n_state = bbpq_pkg::S_RST_READ;
            end
            bbpq_pkg::S_RST_START: n_state = bbpq_pkg::S_RST_FILL;
            bbpq_pkg::S_RST_FILL: begin
                if (i_stat.fill_done) n_state = bbpq_pkg::S_SUMMARY;
            end
            default: n_state = bbpq_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op   = bbpq_pkg::OP_NONE;
        o_cmd.emit = 1'b0;
        o_cmd.res  = bbpq_pkg::RES_SUMMARY;
        o_in_ready = 1'b0;
        unique case (r_state)
            bbpq_pkg::S_INIT_START, bbpq_pkg::S_RST_START: begin
                o_cmd.op = bbpq_pkg::OP_FILL_START;
            end
            bbpq_pkg::S_INIT_FILL, bbpq_pkg::S_RST_FILL: begin
                if (!i_stat.fill_done) o_cmd.op = bbpq_pkg::OP_FILL_STEP;
            end
            bbpq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = bbpq_pkg::OP_LOAD;
            end
            bbpq_pkg::S_DISPATCH: begin
                unique case (i_stat.kind)
                    bbpq_pkg::K_ALLOC, bbpq_pkg::K_PULL: begin
                        if (i_stat.src_nonempty) begin
                            o_cmd.op = bbpq_pkg::OP_SRC_POP;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.member) begin
                                o_cmd.res = bbpq_pkg::RES_WAIT;
                            end else if (i_stat.waiters_full) begin
                                o_cmd.res = bbpq_pkg::RES_REFUSE;
                            end else begin
                                o_cmd.res = bbpq_pkg::RES_WAIT;
                                o_cmd.op  = bbpq_pkg::OP_WL_APPEND;
                            end
                        end
                    end
                    bbpq_pkg::K_PUSH, bbpq_pkg::K_RELEASE: begin
                        if (i_stat.wl_nonempty) begin
                            o_cmd.op = bbpq_pkg::OP_WL_POP;
                        end else if (!i_stat.dst_full) begin
                            o_cmd.op = bbpq_pkg::OP_DST_APPEND;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.res  = bbpq_pkg::RES_DROP;
                        end
                    end
                    bbpq_pkg::K_CANCEL: begin
                        if (!i_stat.member && i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.res  = bbpq_pkg::RES_REFUSE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            bbpq_pkg::S_GRANT: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.res  = bbpq_pkg::RES_GRANT;
            end
            bbpq_pkg::S_HAND: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.res  = bbpq_pkg::RES_HAND;
                    o_cmd.op   = bbpq_pkg::OP_HAND_CLR;
                end
            end
            bbpq_pkg::S_STORED: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.res  = bbpq_pkg::RES_STORED;
            end
            bbpq_pkg::S_CAN_READ: begin
                if (!i_stat.walk_end) begin
                    o_cmd.op = bbpq_pkg::OP_WALK_READ;
                end else if (i_stat.out_free) begin
                    o_cmd.op   = bbpq_pkg::OP_CAN_DROP;
                    o_cmd.emit = 1'b1;
                    o_cmd.res  = bbpq_pkg::RES_CANCEL;
                end
            end
            bbpq_pkg::S_CAN_CHECK: begin
                o_cmd.op = bbpq_pkg::OP_WALK_CHECK;
            end
            bbpq_pkg::S_RST_READ: begin
                if (!i_stat.walk_end) begin
                    o_cmd.op = bbpq_pkg::OP_WALK_READ;
                end else if (!i_stat.last_list) begin
                    o_cmd.op = bbpq_pkg::OP_LIST_NEXT;
                end
            end
            bbpq_pkg::S_RST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.res  = bbpq_pkg::RES_WOKEN;
            end
            bbpq_pkg::S_SUMMARY: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.res  = bbpq_pkg::RES_SUMMARY;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/blocking_buffer_pool_queue.sv =====
// Top level of the blocking buffer pool queue: channels, register port, controller and datapath.
//
// Requests arrive as beats on i_req (kind, requester, buffer_index) and results leave as
// beats on o_rsp; a beat moves when valid and ready are both high at a rising edge.
// Every request gives one result beat except reset pool, which gives one woken beat per
// waiter (push-waiters first, then pull-waiters, oldest first) and a closing summary beat
// with last set; kinds 6 and 7 give none.
// Steps per request, from acceptance to the result being registered:
//   allocate, pull, push, release: the result is formatted in the dispatch state when it needs
//   no ring access (wait, refuse, drop), else one ring memory read or write comes first.
//   cancel: refused in the dispatch state when the requester waits nowhere, else the waiter
//   list is walked entry by entry through the waiter ring's single read port, each entry
//   read in one state and checked in the next, closing the gap as it goes.
//   reset pool: a walk over both waiter rings, one woken beat per waiter, then the
//   one-entry-per-cycle refill of the free ring.
// A new request is taken only when the previous one has finished.
// After i_rst_n the free ring is refilled with min(MAX_BLOCKS, 16) buffers, one per cycle;
// i_req.ready stays low until then, while the register port is served as ever.
// blocks_in_use (address 0) takes effect at the next refill.
// A stalled receiver holds the result in the output register; the controller holds at the
// next beat it has to hand over until that register drains.
`default_nettype none

module blocking_buffer_pool_queue #(
    parameter int MAX_BLOCKS     = bbpq_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_REQUESTERS = bbpq_pkg::DEF_MAX_REQUESTERS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bbpq_req_if.sink    i_req,
    bbpq_rsp_if.source  o_rsp,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    bbpq_pkg::t_cmd    cmd;
    bbpq_pkg::t_stat   stat;
    bbpq_pkg::t_result res;
    logic              res_valid;
    logic              reg_sel;

    logic [bbpq_pkg::CFG_W-1:0] r_blocks;

    // one register: index from paddr[2], byte lanes ignored
    assign reg_sel = paddr[2] == 1'b0;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks <= bbpq_pkg::BLOCKS_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_blocks <= pwdata[bbpq_pkg::CFG_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32 - bbpq_pkg::CFG_W){1'b0}}, r_blocks} : '0;

    bbpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bbpq_datapath #(
        .MAX_BLOCKS     (MAX_BLOCKS),
        .MAX_REQUESTERS (MAX_REQUESTERS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_req.kind),
        .i_requester    (i_req.requester),
        .i_buffer_index (i_req.buffer_index),
        .i_blocks       (r_blocks),
        .o_res_valid    (res_valid),
        .i_res_ready    (o_rsp.ready),
        .o_res          (res)
    );

    // drive the result beat
    assign o_rsp.valid        = res_valid;
    assign o_rsp.status       = res.status;
    assign o_rsp.target       = res.target;
    assign o_rsp.buffer_out   = res.buffer_out;
    assign o_rsp.buffer_valid = res.buffer_valid;
    assign o_rsp.queue_empty  = res.queue_empty;
    assign o_rsp.pool_full    = res.pool_full;
    assign o_rsp.last         = res.last;

endmodule

`default_nettype wire
